@@ rtl/tgr_pkg.sv @@
`default_nettype none

package tgr_pkg;

    // Field and register widths fixed by the interface.
    localparam int TIME_W     = 32;
    localparam int RADIUS_W   = 12;
    localparam int LIMIT_W    = 16;
    localparam int GAIN_W     = 12;
    localparam int OUT_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    // Delta width of the queue entries; it holds the deltas of coordinates up to 16 bits.
    localparam int DELTA_MAX_W = 17;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOVE_RADIUS   = 3'd0,
        CFG_MOVE_DEADZONE = 3'd1,
        CFG_LONG_PRESS    = 3'd2,
        CFG_TAP_LIMIT     = 3'd3,
        CFG_BASE_GAIN     = 3'd4
    } cfg_reg_t;

    // Result codes.
    localparam logic [1:0] EV_MOVE   = 2'd0;
    localparam logic [1:0] EV_DOWN   = 2'd1;
    localparam logic [1:0] EV_UP     = 2'd2;
    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    // Move scaling. The acceleration 1 + 0.08*mag is (25 + 2*mag)/25, and the
    // Q4.8 gain adds a further 1/256, so the product is divided by 6400.
    localparam int SCALE_BIAS  = 25;
    localparam int FRAC_SHIFT  = 8;
    localparam int V_W         = 20;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 25;
    localparam logic [RECIP_W-1:0] RECIP_25 = 21'd1342178;
    localparam int SAT_W = 28;
    localparam logic [SAT_W-1:0] SAT_POS_LIMIT = 28'd209715200;
    localparam logic [SAT_W-1:0] SAT_NEG_LIMIT = 28'd209721600;
    localparam logic [OUT_W-1:0] OUT_POS_MAX   = 16'd32767;
    localparam logic [OUT_W-1:0] OUT_NEG_MAG   = 16'd32768;

    typedef enum logic [1:0] {
        CMD_MOVE,
        CMD_LEFT,
        CMD_RIGHT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                      kind;
        logic signed [DELTA_MAX_W-1:0]  dx;
        logic signed [DELTA_MAX_W-1:0]  dy;
    } cmd_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] move_radius;
        logic [RADIUS_W-1:0] move_deadzone;
        logic [LIMIT_W-1:0]  long_press_limit_ms;
        logic [LIMIT_W-1:0]  tap_limit_ms;
    } front_cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DELTA,
        F_SQUARE,
        F_DECIDE
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQUARE,
        B_SUM,
        B_ROOT,
        B_SCALE,
        B_RECIP,
        B_FINISH,
        B_CLICK_DOWN,
        B_CLICK_UP
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/touchpad_gesture_recognizer_core.sv @@
// Touchpad gesture recognizer. Each input transaction is one touch sample
// (touched flag, x, y, millisecond time). The block tracks the press and its
// running displacement and returns zero, one or two result transactions per
// sample: a scaled, accelerated move once the displacement leaves the drag
// radius, a right click (button down then up) for a still hold past the long
// press limit, or a left click for a quick release. last_of_run marks the
// final result of a sample. The front end takes a new sample only once done
// with the last and turns it into at most one command in a two-entry queue.
// The back end executes commands one at a time: a click steps through the
// down and up states, a move through square, sum, root, scale, reciprocal
// and finish, the root being a bit-by-bit integer square root of dx*dx +
// dy*dy. Moves are thus paced by the back end; samples that cause no move or
// click are absorbed at the front end rate. Configuration is a plain write
// port and must only be written while the block is idle.
`default_nettype none

module touchpad_gesture_recognizer_core
    import tgr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    // Touch sample channel.
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   touched,
    input  wire logic [COORD_BITS-1:0]  pos_x,
    input  wire logic [COORD_BITS-1:0]  pos_y,
    input  wire logic [TIME_W-1:0]      time_ms,

    // Result channel.
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  event_kind,
    output logic signed [OUT_W-1:0]     move_dx,
    output logic signed [OUT_W-1:0]     move_dy,
    output logic [1:0]                  button_id,
    output logic                        last_of_run
);

    // Configuration registers with their reset values. Writes to an index
    // outside the register list are dropped.
    logic [RADIUS_W-1:0] move_radius_reg;
    logic [RADIUS_W-1:0] move_deadzone_reg;
    logic [LIMIT_W-1:0]  long_press_reg;
    logic [LIMIT_W-1:0]  tap_limit_reg;
    logic [GAIN_W-1:0]   base_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_radius_reg   <= 12'd10;
            move_deadzone_reg <= 12'd1;
            long_press_reg    <= 16'd500;
            tap_limit_reg     <= 16'd300;
            base_gain_reg     <= 12'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOVE_RADIUS:   move_radius_reg   <= cfg_data[RADIUS_W-1:0];
                CFG_MOVE_DEADZONE: move_deadzone_reg <= cfg_data[RADIUS_W-1:0];
                CFG_LONG_PRESS:    long_press_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_TAP_LIMIT:     tap_limit_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_BASE_GAIN:     base_gain_reg     <= cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    front_cfg_t front_cfg;

    assign front_cfg.move_radius         = move_radius_reg;
    assign front_cfg.move_deadzone       = move_deadzone_reg;
    assign front_cfg.long_press_limit_ms = long_press_reg;
    assign front_cfg.tap_limit_ms        = tap_limit_reg;

    logic push, pop, q_full, q_empty;
    cmd_t push_cmd, pop_cmd;

    // The front end owns all press state and decides what each sample causes.
    tgr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .touched  (touched),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .time_ms  (time_ms),
        .cfg      (front_cfg),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // The queue lets the front end keep taking samples while a move is
    // still being scaled or a result waits at the output.
    tgr_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // The back end turns each command into result transactions through a
    // registered output stage.
    tgr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .pop         (pop),
        .pop_cmd     (pop_cmd),
        .base_gain   (base_gain_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .move_dx     (move_dx),
        .move_dy     (move_dy),
        .button_id   (button_id),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

@@ rtl/tgr_cmd_fifo.sv @@
`default_nettype none

module tgr_cmd_fifo
    import tgr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             mem_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CMDQ_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command popped from an empty queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

@@ rtl/tgr_front.sv @@
`default_nettype none

module tgr_front
    import tgr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  touched,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire logic [TIME_W-1:0]     time_ms,
    input  front_cfg_t                 cfg,
    output logic                       push,
    output cmd_t                       push_cmd,
    input  wire logic                  q_full
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * CW;
    localparam int MW   = SQW + 1;
    localparam int RRW  = 2 * RADIUS_W;
    localparam int CMPW = (MW > RRW) ? MW : RRW;
    localparam int AW   = (CW > RADIUS_W) ? CW : RADIUS_W;

    front_state_t state_reg, state_next;

    logic                 touched_reg;
    logic [CW-1:0]        x_reg, y_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 pressed_reg, pressed_next;
    logic                 tap_reg, tap_next;
    logic                 rc_reg, rc_next;
    logic [TIME_W-1:0]    start_reg;
    logic [CW-1:0]        prev_x_reg, prev_y_reg;
    logic signed [DW-1:0] sum_x_reg, sum_y_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [TIME_W-1:0]    held_reg;
    logic [SQW-1:0]       sqx_reg, sqy_reg;
    logic [RRW-1:0]       rr_reg;

    logic signed [DW-1:0]   dx_new, dy_new;
    logic signed [2*DW-1:0] prod_x, prod_y;
    logic [DW-1:0]          adx_full, ady_full;
    logic                   small_x, small_y;
    logic                   moved;
    logic                   rc_fire;
    logic                   need_push;
    cmd_kind_t              kind;
    logic                   go;

    assign dx_new = signed'({1'b0, x_reg}) - signed'({1'b0, prev_x_reg});
    assign dy_new = signed'({1'b0, y_reg}) - signed'({1'b0, prev_y_reg});
    assign prod_x = sum_x_reg * sum_x_reg;
    assign prod_y = sum_y_reg * sum_y_reg;

    assign adx_full = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign ady_full = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign small_x  = AW'(adx_full[CW-1:0]) < AW'(cfg.move_deadzone);
    assign small_y  = AW'(ady_full[CW-1:0]) < AW'(cfg.move_deadzone);
    assign moved    = (CMPW'(sqx_reg) + CMPW'(sqy_reg)) > CMPW'(rr_reg);
    assign rc_fire  = !rc_reg && (held_reg >= TIME_W'(cfg.long_press_limit_ms));

    // Decision for a sample of an active press.
    always_comb
    begin
        need_push    = 1'b0;
        kind         = CMD_MOVE;
        tap_next     = tap_reg;
        rc_next      = rc_reg;
        pressed_next = pressed_reg;
        if (moved)
        begin
            tap_next = 1'b0;
            if (!touched_reg)
            begin
                pressed_next = 1'b0;
            end
            else if (!(small_x && small_y))
            begin
                need_push = 1'b1;
            end
        end
        else
        begin
            if (rc_fire)
            begin
                rc_next   = 1'b1;
                tap_next  = 1'b0;
                need_push = 1'b1;
                kind      = CMD_RIGHT;
            end
            if (!touched_reg)
            begin
                if (tap_reg && !rc_fire && (held_reg < TIME_W'(cfg.tap_limit_ms)))
                begin
                    need_push = 1'b1;
                    kind      = CMD_LEFT;
                end
                tap_next     = 1'b0;
                pressed_next = 1'b0;
            end
        end
    end

    assign go = !need_push || !q_full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_DELTA;
                end
            end
            F_DELTA:
            begin
                state_next = pressed_reg ? F_SQUARE : F_IDLE;
            end
            F_SQUARE:
            begin
                state_next = F_DECIDE;
            end
            F_DECIDE:
            begin
                if (go)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == F_IDLE);
        push          = (state_reg == F_DECIDE) && need_push && !q_full;
        push_cmd.kind = kind;
        push_cmd.dx   = DELTA_MAX_W'(dx_reg);
        push_cmd.dy   = DELTA_MAX_W'(dy_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    touched_reg <= touched;
                    x_reg       <= pos_x;
                    y_reg       <= pos_y;
                    now_reg     <= time_ms;
                end
            end
            F_DELTA:
            begin
                if (!pressed_reg)
                begin
                    if (touched_reg)
                    begin
                        start_reg  <= now_reg;
                        prev_x_reg <= x_reg;
                        prev_y_reg <= y_reg;
                        sum_x_reg  <= '0;
                        sum_y_reg  <= '0;
                    end
                end
                else
                begin
                    held_reg <= now_reg - start_reg;
                    if (touched_reg)
                    begin
                        prev_x_reg <= x_reg;
                        prev_y_reg <= y_reg;
                        sum_x_reg  <= sum_x_reg + dx_new;
                        sum_y_reg  <= sum_y_reg + dy_new;
                        dx_reg     <= dx_new;
                        dy_reg     <= dy_new;
                    end
                    else
                    begin
                        dx_reg <= '0;
                        dy_reg <= '0;
                    end
                end
            end
            F_SQUARE:
            begin
                sqx_reg <= prod_x[SQW-1:0];
                sqy_reg <= prod_y[SQW-1:0];
                rr_reg  <= cfg.move_radius * cfg.move_radius;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            pressed_reg <= 1'b0;
            tap_reg     <= 1'b0;
            rc_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == F_DELTA) && !pressed_reg && touched_reg)
            begin
                pressed_reg <= 1'b1;
                tap_reg     <= 1'b1;
                rc_reg      <= 1'b0;
            end
            else if ((state_reg == F_DECIDE) && go)
            begin
                pressed_reg <= pressed_next;
                tap_reg     <= tap_next;
                rc_reg      <= rc_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tgr_back.sv @@
`default_nettype none

module tgr_back
    import tgr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    output logic                   pop,
    input  cmd_t                   pop_cmd,
    input  wire logic [GAIN_W-1:0] base_gain,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             event_kind,
    output logic signed [OUT_W-1:0] move_dx,
    output logic signed [OUT_W-1:0] move_dy,
    output logic [1:0]             button_id,
    output logic                   last_of_run
);

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int RB  = CW + 1;
    localparam int M2W = 2 * RB;
    localparam int SQW = 2 * CW;
    localparam int AW  = CW + GAIN_W;
    localparam int FW  = CW + 3;
    localparam int PW  = AW + FW;
    localparam int QW  = V_W + RECIP_W;
    localparam logic [M2W-1:0] ROOT_BIT0 = {2'b01, {(M2W - 2){1'b0}}};

    back_state_t state_reg, state_next;

    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [1:0]           btn_reg;
    logic [SQW-1:0]       sqx_reg, sqy_reg;
    logic [AW-1:0]        ax_reg, ay_reg;
    logic [M2W-1:0]       rad_reg, root_reg, bit_reg;
    logic [PW-1:0]        px_reg, py_reg;
    logic                 satx_reg, saty_reg;
    logic [QW-1:0]        qpx_reg, qpy_reg;

    logic                 out_valid_reg;
    logic [1:0]           kind_reg;
    logic [OUT_W-1:0]     mdx_reg, mdy_reg;
    logic [1:0]           btn_out_reg;
    logic                 last_reg;

    logic                 negx, negy;
    logic [DW-1:0]        adx_full, ady_full;
    logic [CW-1:0]        adx, ady;
    logic [M2W-1:0]       trial;
    logic [FW-1:0]        factor;
    logic [SAT_W-1:0]     limx, limy;
    logic [OUT_W-1:0]     magx, magy, ox, oy;
    logic                 slot_free;

    logic                 out_load;
    logic [1:0]           kind_next;
    logic [OUT_W-1:0]     mdx_next, mdy_next;
    logic [1:0]           btn_out_next;
    logic                 last_next;

    assign negx     = dx_reg[DW-1];
    assign negy     = dy_reg[DW-1];
    assign adx_full = negx ? DW'(-dx_reg) : DW'(dx_reg);
    assign ady_full = negy ? DW'(-dy_reg) : DW'(dy_reg);
    assign adx      = adx_full[CW-1:0];
    assign ady      = ady_full[CW-1:0];
    assign trial    = root_reg + bit_reg;
    assign factor   = FW'(SCALE_BIAS) + FW'({root_reg[RB-1:0], 1'b0});
    assign limx     = negx ? SAT_NEG_LIMIT : SAT_POS_LIMIT;
    assign limy     = negy ? SAT_NEG_LIMIT : SAT_POS_LIMIT;
    assign slot_free = !out_valid_reg || out_ready;

    // Final magnitude, saturation and the minimum one-unit move.
    always_comb
    begin
        magx = satx_reg ? (negx ? OUT_NEG_MAG : OUT_POS_MAX) : qpx_reg[RECIP_SHIFT +: OUT_W];
        magy = saty_reg ? (negy ? OUT_NEG_MAG : OUT_POS_MAX) : qpy_reg[RECIP_SHIFT +: OUT_W];
        ox   = negx ? (OUT_W'(0) - magx) : magx;
        oy   = negy ? (OUT_W'(0) - magy) : magy;
        if ((ox == '0) && (oy == '0))
        begin
            ox = negx ? '1 : ((dx_reg != '0) ? OUT_W'(1) : '0);
            oy = negy ? '1 : ((dy_reg != '0) ? OUT_W'(1) : '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (pop_cmd.kind == CMD_MOVE) ? B_SQUARE : B_CLICK_DOWN;
                end
            end
            B_SQUARE:
            begin
                state_next = B_SUM;
            end
            B_SUM:
            begin
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                if (bit_reg == '0)
                begin
                    state_next = B_SCALE;
                end
            end
            B_SCALE:
            begin
                state_next = B_RECIP;
            end
            B_RECIP:
            begin
                state_next = B_FINISH;
            end
            B_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_CLICK_DOWN:
            begin
                if (slot_free)
                begin
                    state_next = B_CLICK_UP;
                end
            end
            B_CLICK_UP:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        out_load     = 1'b0;
        kind_next    = EV_MOVE;
        mdx_next     = '0;
        mdy_next     = '0;
        btn_out_next = BTN_NONE;
        last_next    = 1'b1;
        case (state_reg)
            B_IDLE:
            begin
                pop = !q_empty;
            end
            B_FINISH:
            begin
                out_load = slot_free;
                mdx_next = ox;
                mdy_next = oy;
            end
            B_CLICK_DOWN:
            begin
                out_load     = slot_free;
                kind_next    = EV_DOWN;
                btn_out_next = btn_reg;
                last_next    = 1'b0;
            end
            B_CLICK_UP:
            begin
                out_load     = slot_free;
                kind_next    = EV_UP;
                btn_out_next = btn_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                dx_reg  <= pop_cmd.dx[DW-1:0];
                dy_reg  <= pop_cmd.dy[DW-1:0];
                btn_reg <= (pop_cmd.kind == CMD_LEFT) ? BTN_LEFT : BTN_RIGHT;
            end
            B_SQUARE:
            begin
                sqx_reg <= adx * adx;
                sqy_reg <= ady * ady;
                ax_reg  <= adx * base_gain;
                ay_reg  <= ady * base_gain;
            end
            B_SUM:
            begin
                rad_reg  <= M2W'(sqx_reg) + M2W'(sqy_reg);
                root_reg <= '0;
                bit_reg  <= ROOT_BIT0;
            end
            B_ROOT:
            begin
                if (bit_reg != '0)
                begin
                    if (rad_reg >= trial)
                    begin
                        rad_reg  <= rad_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            B_SCALE:
            begin
                px_reg <= ax_reg * factor;
                py_reg <= ay_reg * factor;
            end
            B_RECIP:
            begin
                satx_reg <= px_reg >= PW'(limx);
                saty_reg <= py_reg >= PW'(limy);
                qpx_reg  <= px_reg[FRAC_SHIFT +: V_W] * RECIP_25;
                qpy_reg  <= py_reg[FRAC_SHIFT +: V_W] * RECIP_25;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            kind_reg    <= kind_next;
            mdx_reg     <= mdx_next;
            mdy_reg     <= mdy_next;
            btn_out_reg <= btn_out_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign move_dx     = mdx_reg;
    assign move_dy     = mdy_reg;
    assign button_id   = btn_out_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire
